@@ hw/rtl/multichannel_timed_debouncer_defines.svh @@
// Assertion macros shared by the debouncer RTL.
`ifndef MULTICHANNEL_TIMED_DEBOUNCER_DEFINES_SVH
`define MULTICHANNEL_TIMED_DEBOUNCER_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define MTD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define MTD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/mtd_pkg.sv @@
package mtd_pkg;

	localparam logic [1:0] ACT_EDGE  = 2'd0;
	localparam logic [1:0] ACT_PRIME = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	localparam logic       REG_DEBOUNCE = 1'b0;
	localparam logic       REG_POLL     = 1'b1;

	localparam int         CFG_W          = 16;
	localparam int         TIME_W         = 48;
	localparam logic [7:0] CONNECTOR_BASE = 8'd18;
	localparam logic [15:0] DEBOUNCE_RESET = 16'd5;

	typedef struct packed {
		logic [1:0]        action;
		logic [2:0]        channel;
		logic              level;
		logic [TIME_W-1:0] time_ms;
		logic [7:0]        poll_levels;
	} in_word_t;

	typedef struct packed {
		logic              record_valid;
		logic [7:0]        connector;
		logic              new_state;
		logic [TIME_W-1:0] change_time_ms;
		logic [7:0]        on_mask;
		logic              queue_dropped;
		logic              last;
	} out_word_t;

endpackage

@@ hw/rtl/mtd_ram.sv @@
module mtd_ram #(
	parameter int WIDTH = 49,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/multichannel_timed_debouncer.sv @@
// Timestamp debounce filter for up to eight active-low opto channels.
// A command word is taken when start is high and busy is low; busy then stays
// high until the last result word of that command has been shown.
// Edge commands append a level and time to the channel's sample ring, prime
// commands load the candidate and confirmed state, tick commands drain every
// ring, optionally check the polled pins and confirm stable levels.
// Results appear on result for one cycle each, marked by result_valid, with
// result.last on the final word. The receiver cannot stall the block.
// Edge, prime and unknown commands give one result word, in the cycle after accept.
// A tick visits the channels in turn through one shared subtract-and-compare
// unit: per channel a check state, a ring read and an update per queued sample,
// a poll state and a confirm state; then one word per confirmed channel, or one
// status word if none. The sample ring memory is not cleared; its count keeps
// stale entries unread. Reset restores the debounce time to 5, clears poll_enable
// and all channel state. Configuration is written through cfg_we, cfg_index and
// cfg_data by the user only while idle, which the block does not enforce.
`include "multichannel_timed_debouncer_defines.svh"

module multichannel_timed_debouncer #(
	parameter int CHANNELS    = 4,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  mtd_pkg::in_word_t        cmd,
	output logic                     result_valid,
	output mtd_pkg::out_word_t       result,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [mtd_pkg::CFG_W-1:0] cfg_data
);

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = CH_W + SLOT_W;
	localparam int TW     = mtd_pkg::TIME_W;
	localparam logic [3:0]        CH_LIM   = 4'(CHANNELS);
	localparam logic [CH_W-1:0]   CH_LAST  = CH_W'(CHANNELS - 1);
	localparam logic [CNT_W-1:0]  Q_FULL   = CNT_W'(QUEUE_DEPTH);
	localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(QUEUE_DEPTH - 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_CH   = 7'b0000010,
		S_RD   = 7'b0000100,
		S_TAKE = 7'b0001000,
		S_POLL = 7'b0010000,
		S_CONF = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [15:0]       debounce_q;
	logic              poll_en_q;
	logic [CH_W-1:0]   ch_q;
	logic [TW-1:0]     t_q;
	logic [7:0]        polls_q;
	logic              drop_q;
	logic [CHANNELS-1:0] rec_q;

	logic [SLOT_W-1:0] head_q      [CHANNELS];
	logic [CNT_W-1:0]  count_q     [CHANNELS];
	logic              cand_pres_q [CHANNELS];
	logic              cand_lvl_q  [CHANNELS];
	logic [TW-1:0]     cand_time_q [CHANNELS];
	logic              conf_pres_q [CHANNELS];
	logic              conf_lvl_q  [CHANNELS];

	// Ring memory: level in the top bit, time below.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [TW:0]       ram_rdata;

	logic              accept;
	logic              ch_ok;
	logic [CH_W-1:0]   in_ch;
	logic              full;
	logic [SLOT_W-1:0] head_push;
	logic [CNT_W-1:0]  cnt_push;
	logic [CNT_W:0]    slot_sum;
	logic [SLOT_W-1:0] slot;

	assign accept = start && (state_q == S_IDLE);
	assign ch_ok  = ({1'b0, cmd.channel} < CH_LIM);
	assign in_ch  = CH_W'(cmd.channel);
	assign full   = (count_q[in_ch] == Q_FULL);

	always_comb begin
		head_push = head_q[in_ch];
		cnt_push  = count_q[in_ch];
		if (full) begin
			head_push = (head_q[in_ch] == SLOT_TOP) ? '0 : head_q[in_ch] + 1'b1;
			cnt_push  = Q_FULL - 1'b1;
		end
		slot_sum = (CNT_W+1)'(head_push) + (CNT_W+1)'(cnt_push);
		if (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			slot_sum = slot_sum - (CNT_W+1)'(QUEUE_DEPTH);
		end
		slot = SLOT_W'(slot_sum);
	end

	assign ram_we    = accept && (cmd.action == mtd_pkg::ACT_EDGE) && ch_ok;
	assign ram_waddr = {in_ch, slot};
	assign ram_raddr = {ch_q, head_q[ch_q]};

	mtd_ram #(
		.WIDTH(TW + 1),
		.DEPTH(CHANNELS * (2 ** SLOT_W))
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({cmd.level, cmd.time_ms}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Shared stability unit: tick time minus candidate time against the debounce time.
	logic [TW:0] age;
	logic        stable;
	logic        poll_lvl;
	logic        new_st;
	logic        confirm;

	assign age      = {1'b0, t_q} - {1'b0, cand_time_q[ch_q]};
	assign stable   = !age[TW] && (age[TW-1:0] >= {{(TW-16){1'b0}}, debounce_q});
	assign poll_lvl = polls_q[3'(ch_q)];
	assign new_st   = !cand_lvl_q[ch_q];
	assign confirm  = cand_pres_q[ch_q] && stable &&
		!(conf_pres_q[ch_q] && (conf_lvl_q[ch_q] == new_st));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			debounce_q <= mtd_pkg::DEBOUNCE_RESET;
			poll_en_q  <= 1'b0;
			ch_q       <= '0;
			drop_q     <= 1'b0;
			rec_q      <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				head_q[c]      <= '0;
				count_q[c]     <= '0;
				cand_pres_q[c] <= 1'b0;
				cand_lvl_q[c]  <= 1'b0;
				cand_time_q[c] <= '0;
				conf_pres_q[c] <= 1'b0;
				conf_lvl_q[c]  <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == mtd_pkg::REG_DEBOUNCE) begin
					debounce_q <= cfg_data;
				end else begin
					poll_en_q <= cfg_data[0];
				end
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						t_q     <= cmd.time_ms;
						polls_q <= cmd.poll_levels;
						drop_q  <= (cmd.action == mtd_pkg::ACT_EDGE) && ch_ok && full;
						rec_q   <= '0;
						ch_q    <= '0;
						state_q <= (cmd.action == mtd_pkg::ACT_TICK) ? S_CH : S_OUT;
						if (cmd.action == mtd_pkg::ACT_EDGE && ch_ok) begin
							head_q[in_ch]  <= head_push;
							count_q[in_ch] <= cnt_push + 1'b1;
						end else if (cmd.action == mtd_pkg::ACT_PRIME && ch_ok) begin
							cand_pres_q[in_ch] <= 1'b1;
							cand_lvl_q[in_ch]  <= cmd.level;
							cand_time_q[in_ch] <= cmd.time_ms;
							conf_pres_q[in_ch] <= 1'b1;
							conf_lvl_q[in_ch]  <= !cmd.level;
						end
					end
				end
				S_CH: begin
					state_q <= (count_q[ch_q] != '0) ? S_RD : S_POLL;
				end
				S_RD: begin
					state_q <= S_TAKE;
				end
				S_TAKE: begin
					if (!cand_pres_q[ch_q] || ram_rdata[TW] != cand_lvl_q[ch_q]) begin
						cand_pres_q[ch_q] <= 1'b1;
						cand_lvl_q[ch_q]  <= ram_rdata[TW];
						cand_time_q[ch_q] <= ram_rdata[TW-1:0];
					end
					head_q[ch_q]  <= (head_q[ch_q] == SLOT_TOP) ? '0 : head_q[ch_q] + 1'b1;
					count_q[ch_q] <= count_q[ch_q] - 1'b1;
					state_q       <= (count_q[ch_q] > CNT_W'(1)) ? S_RD : S_POLL;
				end
				S_POLL: begin
					if (poll_en_q && (!cand_pres_q[ch_q] || poll_lvl != cand_lvl_q[ch_q])) begin
						cand_pres_q[ch_q] <= 1'b1;
						cand_lvl_q[ch_q]  <= poll_lvl;
						cand_time_q[ch_q] <= t_q;
					end
					state_q <= S_CONF;
				end
				S_CONF: begin
					if (confirm) begin
						conf_pres_q[ch_q] <= 1'b1;
						conf_lvl_q[ch_q]  <= new_st;
						rec_q[ch_q]       <= 1'b1;
					end
					if (ch_q == CH_LAST) begin
						state_q <= S_OUT;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= S_CH;
					end
				end
				S_OUT: begin
					rec_q <= rec_q & (rec_q - 1'b1);
					if ((rec_q & (rec_q - 1'b1)) == '0) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output word: lowest pending record first, or one status word.
	logic [CH_W-1:0] sel;
	logic [7:0]      mask;

	always_comb begin
		sel = '0;
		for (int c = CHANNELS - 1; c >= 0; c--) begin
			if (rec_q[c]) begin
				sel = CH_W'(c);
			end
		end
		mask = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			mask[c] = conf_pres_q[c] && conf_lvl_q[c];
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = (state_q == S_OUT);

	always_comb begin
		result               = '0;
		result.on_mask       = mask;
		result.last          = ((rec_q & (rec_q - 1'b1)) == '0);
		if (rec_q != '0) begin
			result.record_valid   = 1'b1;
			result.connector      = mtd_pkg::CONNECTOR_BASE + 8'(sel);
			result.new_state      = conf_lvl_q[sel];
			result.change_time_ms = cand_time_q[sel];
		end else begin
			result.queue_dropped  = drop_q;
		end
	end

	`MTD_ASSERT_NOW(a_result_while_busy, result_valid, busy, "result word outside a command")
	`MTD_ASSERT_NEXT(a_last_ends_command, result_valid && result.last, !busy,
		"block still busy after the last word")
	`MTD_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted command did not start")
	`MTD_ASSERT_NOW(a_record_has_no_drop, result_valid && result.record_valid,
		!result.queue_dropped, "record word flagged a dropped sample")

endmodule

@@ tb/sv/multichannel_timed_debouncer_tb.sv @@
module multichannel_timed_debouncer_tb;
	import mtd_pkg::*;

	localparam int NCH = 4;
	localparam int QDEPTH = 8;
	localparam logic [1:0] ACT_UNKNOWN = 2'd3;

	class debounce_scoreboard;
		out_word_t expected_words[$];
		int errors;

		logic [TIME_W-1:0] ring_time[NCH][QDEPTH];
		logic ring_level[NCH][QDEPTH];
		int head[NCH];
		int count[NCH];
		logic cand_valid[NCH];
		logic cand_level[NCH];
		logic [TIME_W-1:0] cand_time[NCH];
		logic conf_valid[NCH];
		logic conf_level[NCH];
		logic [15:0] stable_ms;
		logic poll_on;

		function new();
			errors = 0;
			stable_ms = DEBOUNCE_RESET;
			poll_on = 1'b0;
			for (int c = 0; c < NCH; c++) begin
				head[c] = 0;
				count[c] = 0;
				cand_valid[c] = 0;
				cand_level[c] = 0;
				cand_time[c] = '0;
				conf_valid[c] = 0;
				conf_level[c] = 0;
			end
		endfunction

		function void write_reg(logic idx, logic [CFG_W-1:0] data);
			if (idx == REG_DEBOUNCE)
				stable_ms = data;
			else
				poll_on = data[0];
		endfunction

		function void take_candidate(int c, logic lvl, logic [TIME_W-1:0] t);
			if (!cand_valid[c] || lvl != cand_level[c]) begin
				cand_valid[c] = 1;
				cand_level[c] = lvl;
				cand_time[c] = t;
			end
		endfunction

		// Works out the result words caused by one accepted command word.
		function void note_command(in_word_t w);
			out_word_t words[$];
			out_word_t r;
			logic [7:0] mask;
			int c;
			logic st;
			r = '0;
			if (w.action == ACT_EDGE) begin
				if (w.channel < NCH) begin
					c = w.channel;
					if (count[c] >= QDEPTH) begin
						head[c] = (head[c] + 1) % QDEPTH;
						count[c] = QDEPTH - 1;
						r.queue_dropped = 1;
					end
					ring_time[c][(head[c] + count[c]) % QDEPTH] = w.time_ms;
					ring_level[c][(head[c] + count[c]) % QDEPTH] = w.level;
					count[c]++;
				end
				words.push_back(r);
			end else if (w.action == ACT_PRIME) begin
				if (w.channel < NCH) begin
					c = w.channel;
					cand_valid[c] = 1;
					cand_level[c] = w.level;
					cand_time[c] = w.time_ms;
					conf_valid[c] = 1;
					conf_level[c] = !w.level;
				end
				words.push_back(r);
			end else if (w.action == ACT_TICK) begin
				for (c = 0; c < NCH; c++) begin
					while (count[c] > 0) begin
						take_candidate(c, ring_level[c][head[c]], ring_time[c][head[c]]);
						head[c] = (head[c] + 1) % QDEPTH;
						count[c]--;
					end
					if (poll_on)
						take_candidate(c, w.poll_levels[c], w.time_ms);
					if (!cand_valid[c] || w.time_ms < cand_time[c]
							|| (w.time_ms - cand_time[c]) < stable_ms)
						continue;
					st = !cand_level[c];
					if (conf_valid[c] && conf_level[c] == st)
						continue;
					conf_valid[c] = 1;
					conf_level[c] = st;
					r = '0;
					r.record_valid = 1;
					r.connector = CONNECTOR_BASE + c;
					r.new_state = st;
					r.change_time_ms = cand_time[c];
					words.push_back(r);
				end
				if (words.size() == 0)
					words.push_back('0);
			end else begin
				words.push_back(r);
			end
			mask = '0;
			for (c = 0; c < NCH; c++)
				mask[c] = conf_valid[c] && conf_level[c];
			foreach (words[k]) begin
				words[k].on_mask = mask;
				words[k].last = (k == words.size() - 1);
				expected_words.push_back(words[k]);
			end
		endfunction

		task check_word(out_word_t got);
			out_word_t e;
			if (expected_words.size() == 0) begin
				report_mismatch("result word with nothing expected", 0, 0);
				return;
			end
			e = expected_words.pop_front();
			if (got.record_valid !== e.record_valid)
				report_mismatch("record_valid", got.record_valid, e.record_valid);
			if (got.connector !== e.connector)
				report_mismatch("connector", got.connector, e.connector);
			if (got.new_state !== e.new_state)
				report_mismatch("new_state", got.new_state, e.new_state);
			if (got.change_time_ms !== e.change_time_ms)
				report_mismatch("change_time_ms", got.change_time_ms, e.change_time_ms);
			if (got.on_mask !== e.on_mask)
				report_mismatch("on_mask", got.on_mask, e.on_mask);
			if (got.queue_dropped !== e.queue_dropped)
				report_mismatch("queue_dropped", got.queue_dropped, e.queue_dropped);
			if (got.last !== e.last)
				report_mismatch("last", got.last, e.last);
		endtask

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("mismatch at %0t: %s got %0h, expected %0h", $time, what, got, want);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_word_t cmd;
	logic result_valid;
	out_word_t result;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_data;

	debounce_scoreboard board;
	int idle_pct;
	logic [TIME_W-1:0] now_ms;

	multichannel_timed_debouncer dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.result_valid(result_valid), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			board.check_word(result);
	end

	// Returns at the accepting edge; start stays high until settle, or until the next call inserts idle cycles.
	task send_command(logic [1:0] act, logic [2:0] ch, logic lvl,
			logic [TIME_W-1:0] t, logic [7:0] polls);
		in_word_t w;
		w.action = act;
		w.channel = ch;
		w.level = lvl;
		w.time_ms = t;
		w.poll_levels = polls;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			cmd <= in_word_t'($urandom);
			@(negedge clk);
		end
		cmd <= w;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_command(w);
	endtask

	// Drops start, waits for the last expected word, then leaves the block idle before returning.
	task settle();
		@(negedge clk);
		start <= 1'b0;
		cmd <= in_word_t'($urandom);
		while (board.expected_words.size() != 0)
			@(negedge clk);
		repeat (100)
			@(negedge clk);
	endtask

	task write_reg(logic idx, logic [CFG_W-1:0] data);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		board.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task random_phase(int items);
		int ch;
		int sent;
		sent = 0;
		while (sent < items) begin
			ch = $urandom_range(NCH - 1);
			now_ms += $urandom_range(4);
			case ($urandom_range(9))
				0: begin
					send_command(ACT_PRIME, ch, $urandom, now_ms, $urandom);
					sent++;
				end
				1: begin
					send_command($urandom_range(3), $urandom, $urandom,
						{$urandom, $urandom}, $urandom);
					sent++;
				end
				2, 3, 4: begin
					send_command(ACT_TICK, $urandom, $urandom, now_ms, $urandom);
					sent++;
				end
				default: begin
					// Bounce bursts, sometimes long enough to overflow the ring.
					repeat ($urandom_range(1, 10)) begin
						send_command(ACT_EDGE, ch, $urandom, now_ms, $urandom);
						now_ms += $urandom_range(1);
						sent++;
					end
				end
			endcase
		end
	endtask

	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_data = '0;
		idle_pct = 0;
		now_ms = 48'd100;
		repeat (12)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: every action, range ends, ring overflow, backwards time.
		send_command(ACT_TICK, 0, 0, 0, 8'h00);
		send_command(ACT_PRIME, 0, 0, 48'd10, 8'h00);
		send_command(ACT_PRIME, 1, 1, 48'hFFFF_FFFF_FFFF, 8'hFF);
		send_command(ACT_PRIME, 7, 0, 0, 8'h00);
		send_command(ACT_EDGE, 7, 1, 48'd5, 8'hFF);
		send_command(ACT_UNKNOWN, 3, 1, 48'hFFFF_FFFF_FFFF, 8'hFF);
		for (int i = 0; i < 9; i++)
			send_command(ACT_EDGE, 3, i[0], 48'd20 + i, 8'h00);
		send_command(ACT_TICK, 0, 0, 48'd26, 8'h00);
		send_command(ACT_TICK, 0, 0, 48'd40, 8'h00);
		send_command(ACT_EDGE, 2, 0, 48'd60, 8'h55);
		send_command(ACT_TICK, 0, 0, 48'd50, 8'h00);
		send_command(ACT_TICK, 0, 0, 48'd100, 8'hAA);

		write_reg(REG_DEBOUNCE, 16'd0);
		write_reg(REG_POLL, 16'd1);
		send_command(ACT_TICK, 0, 0, 48'd101, 8'h0F);
		send_command(ACT_TICK, 0, 0, 48'd102, 8'h00);
		random_phase(30);

		write_reg(REG_DEBOUNCE, 16'hFFFF);
		write_reg(REG_POLL, 16'd0);
		idle_pct = 62;
		send_command(ACT_PRIME, 0, 1, 48'd0, 8'h00);
		send_command(ACT_TICK, 0, 0, 48'd65535, 8'h00);
		random_phase(20);

		write_reg(REG_DEBOUNCE, 16'd3);
		idle_pct = 21;
		random_phase(30);

		write_reg(REG_POLL, 16'd1);
		write_reg(REG_DEBOUNCE, 16'd2);
		idle_pct = 0;
		random_phase(30);

		settle();
		if (board.errors == 0 && board.expected_words.size() == 0) begin
			$display("status: pass");
		end else begin
			if (board.expected_words.size() != 0)
				board.report_mismatch("words still expected", board.expected_words.size(), 0);
			$display("status: fail");
		end
		$finish;
	end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/mtd_pkg.sv
hw/rtl/mtd_ram.sv
hw/rtl/multichannel_timed_debouncer.sv
tb/sv/multichannel_timed_debouncer_tb.sv
